### rtl/assert_macros.svh
// Assertion macros used by the checker top file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define CHK_IMPL(lbl, a, c) lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
  else $error("check failed");
`define CHK_NEXT(lbl, a, c) lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
  else $error("check failed");
`endif

### rtl/ctsc_pkg.sv
// Package for the camera trigger sync checker: widths, codes, reset values.
// No dependencies.
package ctsc_pkg;
  localparam int TS_W = 63;
  localparam int IV_W = 30;
  localparam int PH_W = 13;
  localparam int OFF_W = 31;
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int PHASE_FULL = 3600;
  localparam logic [1:0] ACT_TRIG = 2'd0;
  localparam logic [1:0] ACT_CAM = 2'd1;
  localparam logic [1:0] ACT_CHECK = 2'd2;
  localparam logic [2:0] REG_IV = 3'd0;
  localparam logic [2:0] REG_PH = 3'd1;
  localparam logic [2:0] REG_TTOL = 3'd2;
  localparam logic [2:0] REG_CTOL = 3'd3;
  localparam logic [2:0] REG_OFF = 3'd4;
  localparam logic [2:0] REG_DLY = 3'd5;
  localparam logic [IV_W-1:0] IV_RST = 30'd100000000;
  localparam logic [IV_W-1:0] TTOL_RST = 30'd1000000;
  localparam logic [IV_W-1:0] CTOL_RST = 30'd10000000;
endpackage

### rtl/ctsc_if.sv
// Valid/ready channel interfaces for input and result words.
// Depends on ctsc_pkg.
interface ctsc_in_if import ctsc_pkg::*; ();
  logic valid;
  logic ready;
  logic [1:0] action;
  logic [TS_W-1:0] timestamp_ns;
  modport source (output valid, action, timestamp_ns, input ready);
  modport sink (input valid, action, timestamp_ns, output ready);
endinterface

interface ctsc_out_if import ctsc_pkg::*; ();
  logic valid;
  logic ready;
  logic overall_level;
  logic trigger_level;
  logic [IV_W-1:0] trigger_diff_ns;
  logic camera_level;
  logic signed [63:0] camera_diff_ns;
  modport source (output valid, overall_level, trigger_level, trigger_diff_ns,
                  camera_level, camera_diff_ns, input ready);
  modport sink (input valid, overall_level, trigger_level, trigger_diff_ns,
                camera_level, camera_diff_ns, output ready);
endinterface

### rtl/camera_trigger_sync_checker_top.sv
// Camera trigger sync checker: in channel takes push/check words, out channel
// gives one result word per matched check. APB register port for settings.
// Words are accepted one at a time. A check walks the queue heads, one pair
// compare per S_READ/S_CMP pass, then runs two bit-serial divisions (phase
// shift /3600; grid remainder).
// Reset empties both queues and loads register defaults; no clearing pass.
// A result sits in the output register until taken; while it waits the next
// push is still accepted, but a following check is held at the input until
// the result is taken.
// Queues hold QUEUE_DEPTH stamps each; a push to a full queue is dropped.
`include "assert_macros.svh"
module camera_trigger_sync_checker_top import ctsc_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  ctsc_in_if.sink in_ch,
  ctsc_out_if.source out_ch,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [4:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_READ  = 7'b0000010,
    S_CMP   = 7'b0000100,
    S_SHDIV = 7'b0001000,
    S_SHWT  = 7'b0010000,
    S_MDIV  = 7'b0100000,
    S_MWT   = 7'b1000000
  } state_t;
  state_t state;

  logic [IV_W-1:0] iv_reg, ttol_reg, ctol_reg, dly_reg;
  logic signed [PH_W-1:0] ph_reg;
  logic signed [OFF_W-1:0] off_reg;
  logic wr;
  logic [2:0] ridx;
  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  assign ridx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      iv_reg <= IV_RST; ph_reg <= '0; ttol_reg <= TTOL_RST;
      ctol_reg <= CTOL_RST; off_reg <= '0; dly_reg <= '0;
    end else if (wr && paddr[1:0] == 2'b00) begin
      case (ridx)
        REG_IV: iv_reg <= pwdata[IV_W-1:0];
        REG_PH: ph_reg <= pwdata[PH_W-1:0];
        REG_TTOL: ttol_reg <= pwdata[IV_W-1:0];
        REG_CTOL: ctol_reg <= pwdata[IV_W-1:0];
        REG_OFF: off_reg <= pwdata[OFF_W-1:0];
        REG_DLY: dly_reg <= pwdata[IV_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_IV: prdata = {2'b00, iv_reg};
      REG_PH: prdata = {{(32-PH_W){ph_reg[PH_W-1]}}, ph_reg};
      REG_TTOL: prdata = {2'b00, ttol_reg};
      REG_CTOL: prdata = {2'b00, ctol_reg};
      REG_OFF: prdata = {off_reg[OFF_W-1], off_reg};
      REG_DLY: prdata = {2'b00, dly_reg};
      default: prdata = '0;
    endcase
  end

  // queues
  logic [TS_W-1:0] tmem [QUEUE_DEPTH];
  logic [TS_W-1:0] cmem [QUEUE_DEPTH];
  logic [AW-1:0] thead, chead;
  logic [FW-1:0] tfill, cfill;
  logic [TS_W-1:0] trd, crd;
  logic in_acc;
  logic out_busy;

  function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] h, logic [FW-1:0] f);
    logic [AW+FW:0] s;
    s = (AW+FW+1)'(h) + (AW+FW+1)'(f);
    if (s >= (AW+FW+1)'(QUEUE_DEPTH)) s = s - (AW+FW+1)'(QUEUE_DEPTH);
    return s[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] inc(logic [AW-1:0] h);
    return (32'(h) + 1 >= QUEUE_DEPTH) ? '0 : h + 1'b1;
  endfunction

  assign in_ch.ready = (state == S_IDLE) &&
                       !(out_busy && in_ch.action == ACT_CHECK);
  assign in_acc = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (in_acc && in_ch.action == ACT_TRIG && tfill != FW'(QUEUE_DEPTH))
      tmem[wrap_add(thead, tfill)] <= in_ch.timestamp_ns;
    if (in_acc && in_ch.action == ACT_CAM && cfill != FW'(QUEUE_DEPTH))
      cmem[wrap_add(chead, cfill)] <= in_ch.timestamp_ns;
    trd <= tmem[thead];
    crd <= cmem[chead];
  end

  // compare path
  logic [IV_W-1:0] ive;
  logic signed [64:0] raw, lag65, lo, hi;
  logic signed [63:0] lag_sat;
  logic too_old_cam, too_old_trig;
  assign ive = (iv_reg == '0) ? IV_W'(1) : iv_reg;
  assign raw = $signed({2'b00, crd}) - $signed({2'b00, trd});
  assign lag65 = raw - 65'(off_reg);
  assign lag_sat = (lag65 > 65'sh7FFF_FFFF_FFFF_FFFF) ? 64'sh7FFF_FFFF_FFFF_FFFF :
                   (lag65 < -65'sh8000_0000_0000_0000) ? 64'sh8000_0000_0000_0000 :
                   lag65[63:0];
  assign lo = 65'(dly_reg) - 65'(ive[IV_W-1:1]);
  assign hi = 65'(dly_reg) + 65'(ive[IV_W-1:1]);
  assign too_old_cam = 65'(lag_sat) < lo;
  assign too_old_trig = hi < 65'(lag_sat);

  // divider
  logic dstart, ddone;
  logic [63:0] dnum, dquo;
  logic [IV_W-1:0] dden, drem;
  ctsc_serdiv #(.NW(64), .DW(IV_W)) u_div (
    .clk(clk), .rst(rst), .start(dstart), .num(dnum), .den(dden),
    .done(ddone), .quo(dquo), .rem(drem)
  );

  logic [TS_W-1:0] trig_k;
  logic signed [63:0] lag_k;
  logic [63:0] shmag;
  logic shneg;
  logic signed [44:0] prod;
  assign prod = $signed({1'b0, ive}) * ph_reg;

  always_comb begin
    dstart = 1'b0;
    dnum = '0;
    dden = ive;
    if (state == S_SHDIV) begin
      dstart = 1'b1;
      dnum = prod[44] ? 64'(-prod) : 64'(prod);
      dden = IV_W'(PHASE_FULL);
    end else if (state == S_MDIV) begin
      dstart = 1'b1;
      dnum = shmag;
      dden = ive;
    end
  end

  // magnitude of trig - shift, shift = +/- dquo
  logic [63:0] mag;
  always_comb begin
    if (shneg) mag = 64'(trig_k) + dquo;
    else if (64'(trig_k) >= dquo) mag = 64'(trig_k) - dquo;
    else mag = dquo - 64'(trig_k);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      thead <= '0; chead <= '0; tfill <= '0; cfill <= '0;
      out_busy <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) out_busy <= 1'b0;
      case (state)
        S_IDLE: if (in_acc) begin
          if (in_ch.action == ACT_TRIG && tfill != FW'(QUEUE_DEPTH)) tfill <= tfill + 1'b1;
          if (in_ch.action == ACT_CAM && cfill != FW'(QUEUE_DEPTH)) cfill <= cfill + 1'b1;
          if (in_ch.action == ACT_CHECK && tfill != '0 && cfill != '0) state <= S_READ;
        end
        S_READ: state <= S_CMP;
        S_CMP: begin
          if (too_old_cam || too_old_trig) begin
            if (too_old_cam) begin chead <= inc(chead); cfill <= cfill - 1'b1; end
            else begin thead <= inc(thead); tfill <= tfill - 1'b1; end
            if ((too_old_cam && cfill == FW'(1)) || (too_old_trig && tfill == FW'(1))) begin
              if (too_old_cam) begin thead <= inc(thead); tfill <= tfill - 1'b1; end
              else begin chead <= inc(chead); cfill <= cfill - 1'b1; end
              state <= S_IDLE;
            end else state <= S_READ;
          end else begin
            chead <= inc(chead); cfill <= cfill - 1'b1;
            thead <= inc(thead); tfill <= tfill - 1'b1;
            trig_k <= trd; lag_k <= lag_sat;
            shneg <= prod[44];
            state <= S_SHDIV;
          end
        end
        S_SHDIV: state <= S_SHWT;
        S_SHWT: if (ddone) begin shmag <= mag; state <= S_MDIV; end
        S_MDIV: state <= S_MWT;
        S_MWT: if (ddone) begin
          out_ch.trigger_diff_ns <= drem;
          out_ch.trigger_level <= !(drem < ttol_reg);
          out_ch.camera_level <= !(lag_k < $signed(64'(ctol_reg)));
          out_ch.overall_level <= !(drem < ttol_reg) || !(lag_k < $signed(64'(ctol_reg)));
          out_ch.camera_diff_ns <= lag_k;
          out_busy <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
  assign out_ch.valid = out_busy;

  `CHK_IMPL(a_fill_t, 1'b1, tfill <= FW'(QUEUE_DEPTH))
  `CHK_IMPL(a_fill_c, 1'b1, cfill <= FW'(QUEUE_DEPTH))
  `CHK_NEXT(a_res_hold, out_ch.valid && !out_ch.ready, out_ch.valid)
  `CHK_IMPL(a_cmp_nonempty, state == S_CMP, tfill != '0 && cfill != '0)
endmodule

### rtl/ctsc_serdiv.sv
// Bit-serial unsigned divider, quotient and remainder: one quotient bit per cycle.
// Depends on ctsc_pkg.
module ctsc_serdiv import ctsc_pkg::*; #(
  parameter int NW = 64,
  parameter int DW = 30
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo,
  output logic [DW-1:0] rem
);
  localparam int CW = $clog2(NW + 1);
  logic [NW-1:0] sh;
  logic [DW:0] r;
  logic [DW-1:0] d;
  logic [CW-1:0] cnt;
  logic busy;
  logic [DW+1:0] trial;

  assign trial = {r, sh[NW-1]} - {2'b00, d};
  assign rem = r[DW-1:0];
  assign quo = sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CW'(NW);
        sh <= num;
        r <= '0;
        d <= den;
      end else if (busy) begin
        if (trial[DW+1]) begin
          r <= {r[DW-1:0], sh[NW-1]};
          sh <= {sh[NW-2:0], 1'b0};
        end else begin
          r <= trial[DW:0];
          sh <= {sh[NW-2:0], 1'b1};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
